// ----- sv/ppmp6_pkg.sv -----
package ppmp6_pkg;

   // widest number the header may carry, in bits
   localparam int DIM_BITS = 16;
   // product of the accumulator and ten needs four more bits
   localparam int PROD_BITS = DIM_BITS + 4;

   // result status codes
   localparam logic [3:0] ST_HEADER = 4'd0;
   localparam logic [3:0] ST_HDR_OK = 4'd1;
   localparam logic [3:0] ST_PIXEL  = 4'd2;
   localparam logic [3:0] ST_EXTRA  = 4'd3;
   localparam logic [3:0] ST_DONE   = 4'd4;
   localparam logic [3:0] ST_MAGIC  = 4'd5;
   localparam logic [3:0] ST_SYNTAX = 4'd6;
   localparam logic [3:0] ST_LARGE  = 4'd7;
   localparam logic [3:0] ST_VALUES = 4'd8;
   localparam logic [3:0] ST_TRUNC  = 4'd9;
   localparam logic [3:0] ST_AFTER  = 4'd10;

   // characters of interest
   localparam logic [7:0] CHAR_P     = 8'h50;
   localparam logic [7:0] CHAR_SIX   = 8'h36;
   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] MAXVAL_OK  = 8'd255;

   // channel index of the last colour of a pixel
   localparam logic [1:0] CH_BLUE = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_end;
   } req_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic [7:0]  pixel_value;
      logic [1:0]  channel_index;
      logic [15:0] column;
      logic [15:0] row;
      logic        last_pixel_byte;
   } rsp_type;

endpackage

// ----- sv/ppmp6_parse_core.sv -----
module ppmp6_parse_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  ppmp6_pkg::req_type item,
   output ppmp6_pkg::rsp_type result
);

   // parser phases
   localparam logic [2:0] PH_MAGIC0  = 3'd0;
   localparam logic [2:0] PH_MAGIC1  = 3'd1;
   localparam logic [2:0] PH_NUMBERS = 3'd2;
   localparam logic [2:0] PH_PIXELS  = 3'd3;
   localparam logic [2:0] PH_DONE    = 3'd4;
   localparam logic [2:0] PH_ERROR   = 3'd5;

   // header field being parsed
   localparam logic [1:0] FLD_WIDTH  = 2'd0;
   localparam logic [1:0] FLD_HEIGHT = 2'd1;
   localparam logic [1:0] FLD_MAXVAL = 2'd2;

   localparam int DB = ppmp6_pkg::DIM_BITS;

   logic [2:0]    phase_ff, phase_in;
   logic [1:0]    field_ff, field_in;
   logic          in_comment_ff, in_comment_in;
   logic          in_digits_ff, in_digits_in;
   logic [DB-1:0] acc_ff, acc_in;
   logic [DB-1:0] width_ff, width_in;
   logic [DB-1:0] height_ff, height_in;
   logic [1:0]    chan_ff, chan_in;
   logic [DB-1:0] col_ff, col_in;
   logic [DB-1:0] row_ff, row_in;

   logic [7:0]    byte_v;
   logic          is_digit;
   logic          is_space;
   logic [3:0]    digit;
   logic [ppmp6_pkg::PROD_BITS-1:0] product;
   logic          too_large;
   logic          do_skip;
   logic          do_finish;
   logic          values_bad;
   logic          last;
   logic [DB:0]   col_next;
   logic [3:0]    status;

   // classify the incoming byte
   assign byte_v   = item.data_byte;
   assign is_digit = byte_v inside {[8'h30:8'h39]};
   assign is_space = byte_v inside {8'h20, 8'h09, 8'h0D, 8'h0A};
   assign digit    = 4'(byte_v - ppmp6_pkg::CHAR_ZERO);

   // accumulate one decimal digit: acc * 10 = acc * 8 + acc * 2
   assign product = (ppmp6_pkg::PROD_BITS'(acc_ff) << 3)
                  + (ppmp6_pkg::PROD_BITS'(acc_ff) << 1)
                  + ppmp6_pkg::PROD_BITS'(digit);
   assign too_large = |product[ppmp6_pkg::PROD_BITS-1:DB];

   // header check on the byte after maxval
   assign values_bad = (width_ff == '0) || (height_ff == '0)
                    || (acc_ff != DB'(ppmp6_pkg::MAXVAL_OK));

   // pixel position bookkeeping
   assign last = (chan_ff == ppmp6_pkg::CH_BLUE)
              && (col_ff == width_ff - DB'(1))
              && (row_ff == height_ff - DB'(1));
   assign col_next = {1'b0, col_ff} + (DB+1)'(1);

   // next state and status of one word
   always_comb begin
      phase_in      = phase_ff;
      field_in      = field_ff;
      in_comment_in = in_comment_ff;
      in_digits_in  = in_digits_ff;
      acc_in        = acc_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      chan_in       = chan_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      status        = ppmp6_pkg::ST_HEADER;
      do_skip       = 1'b0;
      do_finish     = 1'b0;

      case (phase_ff)
         PH_MAGIC0: begin
            if (item.is_end) begin
               status   = ppmp6_pkg::ST_TRUNC;
               phase_in = PH_ERROR;
            end else if (byte_v != ppmp6_pkg::CHAR_P) begin
               status   = ppmp6_pkg::ST_MAGIC;
               phase_in = PH_ERROR;
            end else begin
               phase_in = PH_MAGIC1;
            end
         end
         PH_MAGIC1: begin
            if (item.is_end) begin
               status   = ppmp6_pkg::ST_TRUNC;
               phase_in = PH_ERROR;
            end else if (byte_v != ppmp6_pkg::CHAR_SIX) begin
               status   = ppmp6_pkg::ST_MAGIC;
               phase_in = PH_ERROR;
            end else begin
               phase_in = PH_NUMBERS;
            end
         end
         PH_NUMBERS: begin
            if (item.is_end) begin
               // end right after maxval digits reports bad values first
               if (in_digits_ff && field_ff == FLD_MAXVAL && values_bad) begin
                  status = ppmp6_pkg::ST_VALUES;
               end else begin
                  status = ppmp6_pkg::ST_TRUNC;
               end
               in_digits_in = 1'b0;
               phase_in     = PH_ERROR;
            end else if (!in_digits_ff) begin
               do_skip = 1'b1;
            end else if (is_digit) begin
               if (too_large) begin
                  status   = ppmp6_pkg::ST_LARGE;
                  phase_in = PH_ERROR;
               end else begin
                  acc_in = product[DB-1:0];
               end
            end else begin
               // a non-digit closes the number
               in_digits_in = 1'b0;
               case (field_ff)
                  FLD_WIDTH: begin
                     width_in = acc_ff;
                     field_in = FLD_HEIGHT;
                     do_skip  = 1'b1;
                  end
                  FLD_HEIGHT: begin
                     height_in = acc_ff;
                     field_in  = FLD_MAXVAL;
                     do_skip   = 1'b1;
                  end
                  default: begin
                     do_finish = 1'b1;
                  end
               endcase
            end

            // whitespace scan for bytes outside a number and for the byte that closed one
            if (do_skip) begin
               if (in_comment_ff) begin
                  if (byte_v == ppmp6_pkg::CHAR_LF) begin
                     in_comment_in = 1'b0;
                  end
               end else if (byte_v == ppmp6_pkg::CHAR_HASH) begin
                  in_comment_in = 1'b1;
               end else if (is_space) begin
                  status = ppmp6_pkg::ST_HEADER;
               end else if (is_digit) begin
                  in_digits_in = 1'b1;
                  acc_in       = DB'(digit);
               end else begin
                  status   = ppmp6_pkg::ST_SYNTAX;
                  phase_in = PH_ERROR;
               end
            end

            // separator after maxval
            if (do_finish) begin
               if (values_bad) begin
                  status   = ppmp6_pkg::ST_VALUES;
                  phase_in = PH_ERROR;
               end else begin
                  status   = ppmp6_pkg::ST_HDR_OK;
                  phase_in = PH_PIXELS;
                  chan_in  = '0;
                  col_in   = '0;
                  row_in   = '0;
               end
            end
         end
         PH_PIXELS: begin
            if (item.is_end) begin
               status   = ppmp6_pkg::ST_TRUNC;
               phase_in = PH_ERROR;
            end else begin
               status = ppmp6_pkg::ST_PIXEL;
               if (last) begin
                  phase_in = PH_DONE;
               end else if (chan_ff != ppmp6_pkg::CH_BLUE) begin
                  chan_in = chan_ff + 2'd1;
               end else begin
                  chan_in = '0;
                  if (col_next >= {1'b0, width_ff}) begin
                     col_in = '0;
                     row_in = row_ff + DB'(1);
                  end else begin
                     col_in = col_next[DB-1:0];
                  end
               end
            end
         end
         PH_DONE: begin
            status = item.is_end ? ppmp6_pkg::ST_DONE : ppmp6_pkg::ST_EXTRA;
         end
         default: begin
            status = ppmp6_pkg::ST_AFTER;
         end
      endcase
   end

   // build the result word
   always_comb begin
      result                 = '0;
      result.status          = status;
      result.image_width     = 16'(width_in);
      result.image_height    = 16'(height_in);
      if (phase_ff == PH_PIXELS && !item.is_end) begin
         result.pixel_value     = byte_v;
         result.channel_index   = chan_ff;
         result.column          = 16'(col_ff);
         result.row             = 16'(row_ff);
         result.last_pixel_byte = last;
      end
   end

   // advance parser state on each word that moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_MAGIC0;
         field_ff      <= FLD_WIDTH;
         in_comment_ff <= 1'b0;
         in_digits_ff  <= 1'b0;
         acc_ff        <= '0;
         width_ff      <= '0;
         height_ff     <= '0;
         chan_ff       <= '0;
         col_ff        <= '0;
         row_ff        <= '0;
      end else if (advance) begin
         phase_ff      <= phase_in;
         field_ff      <= field_in;
         in_comment_ff <= in_comment_in;
         in_digits_ff  <= in_digits_in;
         acc_ff        <= acc_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         chan_ff       <= chan_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
      end
   end

endmodule

// ----- sv/ppm_p6_stream_parser.sv -----
// Streaming parser for a binary P6 image file.
// Request channel: one file byte per word (data_byte), or an end marker
// (is_end set, byte ignored). Response channel: exactly one word for each
// request word, carrying a status code, the parsed width and height, and
// for pixel bytes the value, colour channel, column, row and a flag on the
// final pixel byte.
// The accepted word sits in the input register, then the parse logic loads
// the response register once that register is free. Throughput is one
// word per cycle while rsp_stall is low; the parser state update is the
// loop that sets it.
// Reset (synchronous, active high) returns the parser to expect the first
// magic byte, clears the stored dimensions and empties both registers.
// When the receiver holds rsp_stall, the response word is held, the input
// register fills, and req_stall rises once both registers are full.
// Errors are sticky: after any error status every word reports the
// after-error status until reset.
module ppm_p6_stream_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  ppmp6_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output ppmp6_pkg::rsp_type rsp_data
);

   logic               in_valid_ff;
   ppmp6_pkg::req_type in_data_ff;
   logic               out_valid_ff;
   ppmp6_pkg::rsp_type out_data_ff;
   ppmp6_pkg::rsp_type result;
   logic               out_free;
   logic               advance;

   // move a word to the output when the output register is free
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   ppmp6_parse_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_data_ff),
      .result  (result)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_data_ff <= req_data;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // input stage stalls only when it holds a word and the output is blocked
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("input stalled without a blocked output");

   // pixel fields stay zero outside pixel words
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ppmp6_pkg::ST_PIXEL) |->
      (rsp_data.pixel_value == 8'd0 && rsp_data.last_pixel_byte == 1'b0
       && rsp_data.channel_index == 2'd0))
      else $error("pixel fields set on a non-pixel word");

   // final pixel byte is always the blue channel of a pixel word
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last_pixel_byte) |->
      (rsp_data.status == ppmp6_pkg::ST_PIXEL
       && rsp_data.channel_index == ppmp6_pkg::CH_BLUE))
      else $error("last pixel flag on a wrong word");

   // a word taken from the input reaches the output register next cycle
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("parsed word lost");

endmodule

// ----- test/ppm_p6_stream_parser_tb.sv -----
module ppm_p6_stream_parser_tb;

   // characters the pixel format treats as blanks, besides the line feed, and the digit nine
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // largest value a header number may reach
   localparam longint unsigned NUM_LIMIT = (64'd1 << ppmp6_pkg::DIM_BITS) - 1;

   localparam int QUIET_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 6;
   localparam int WORDS_WANTED = 400;
   localparam int MAX_PRINTED  = 100;

   typedef enum {
      WANT_P, WANT_SIX, HEADER_NUMBERS, PIXEL_DATA, PIXELS_DONE, STUCK_ERROR
   } parse_phase_type;

   typedef enum {
      CLEAN_FILE, CUT_SHORT, BAD_MAGIC, STRAY_CHAR, OVERSIZE, BAD_VALUES
   } stream_kind_type;

   function automatic bit is_digit(logic [7:0] b);
      return b >= ppmp6_pkg::CHAR_ZERO && b <= CHAR_NINE;
   endfunction

   function automatic bit is_blank(logic [7:0] b);
      return b == CHAR_SPACE || b == CHAR_TAB || b == CHAR_CR || b == ppmp6_pkg::CHAR_LF;
   endfunction

   // most gaps short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      else if (r < 92) return $urandom_range(1, 3);
      else return $urandom_range(8, 30);
   endfunction

   // Tracks the parser state for each accepted byte word and holds the
   // result words still to come back from the block.
   class p6_parse_tracker;
      ppmp6_pkg::rsp_type awaited_results[$];
      int                 mismatches;
      int                 results_seen;
      int                 status_tally[16];
      parse_phase_type    phase;
      bit [1:0]           field_sel;
      bit                 in_comment;
      bit                 in_digits;
      int unsigned        acc;
      int unsigned        width_v;
      int unsigned        height_v;
      int unsigned        maxval_v;
      bit [1:0]           chan;
      int unsigned        col_n;
      int unsigned        row_n;

      function new();
         phase      = WANT_P;
         field_sel  = 0;
         in_comment = 0;
         in_digits  = 0;
         acc        = 0;
         width_v    = 0;
         height_v   = 0;
         maxval_v   = 0;
         chan       = 0;
         col_n      = 0;
         row_n      = 0;
      endfunction

      function logic [3:0] fail_with(logic [3:0] code);
         phase = STUCK_ERROR;
         return code;
      endfunction

      // separator after maxval: check the values, open the pixel data
      function logic [3:0] close_header();
         maxval_v  = acc;
         in_digits = 0;
         if (width_v == 0 || height_v == 0 || maxval_v != ppmp6_pkg::MAXVAL_OK)
            return fail_with(ppmp6_pkg::ST_VALUES);
         phase = PIXEL_DATA;
         chan  = 0;
         col_n = 0;
         row_n = 0;
         return ppmp6_pkg::ST_HDR_OK;
      endfunction

      // blanks and comments ahead of a number, or its first digit
      function logic [3:0] skip_header_byte(logic [7:0] b);
         if (in_comment) begin
            if (b == ppmp6_pkg::CHAR_LF) in_comment = 0;
            return ppmp6_pkg::ST_HEADER;
         end
         if (b == ppmp6_pkg::CHAR_HASH) begin
            in_comment = 1;
            return ppmp6_pkg::ST_HEADER;
         end
         if (is_blank(b)) return ppmp6_pkg::ST_HEADER;
         if (is_digit(b)) begin
            in_digits = 1;
            acc = 32'(b - ppmp6_pkg::CHAR_ZERO);
            return ppmp6_pkg::ST_HEADER;
         end
         return fail_with(ppmp6_pkg::ST_SYNTAX);
      endfunction

      function void take_byte_word(ppmp6_pkg::req_type w);
         ppmp6_pkg::rsp_type r;
         logic [3:0]         st;
         logic [7:0]         b;
         longint unsigned    grown;
         r  = '0;
         b  = w.data_byte;
         st = ppmp6_pkg::ST_HEADER;
         case (phase)
            WANT_P: begin
               if (w.is_end) st = fail_with(ppmp6_pkg::ST_TRUNC);
               else if (b != ppmp6_pkg::CHAR_P) st = fail_with(ppmp6_pkg::ST_MAGIC);
               else phase = WANT_SIX;
            end
            WANT_SIX: begin
               if (w.is_end) st = fail_with(ppmp6_pkg::ST_TRUNC);
               else if (b != ppmp6_pkg::CHAR_SIX) st = fail_with(ppmp6_pkg::ST_MAGIC);
               else phase = HEADER_NUMBERS;
            end
            HEADER_NUMBERS: begin
               if (w.is_end) begin
                  // an end straight after maxval digits acts as the separator
                  if (in_digits && field_sel == 2) begin
                     st = close_header();
                     if (st == ppmp6_pkg::ST_HDR_OK) st = fail_with(ppmp6_pkg::ST_TRUNC);
                  end else begin
                     st = fail_with(ppmp6_pkg::ST_TRUNC);
                  end
               end else if (!in_digits) begin
                  st = skip_header_byte(b);
               end else if (is_digit(b)) begin
                  grown = longint'(acc) * 10 + longint'(b - ppmp6_pkg::CHAR_ZERO);
                  if (grown > NUM_LIMIT) st = fail_with(ppmp6_pkg::ST_LARGE);
                  else acc = 32'(grown);
               end else begin
                  // the byte ending width or height is parsed again
                  in_digits = 0;
                  if (field_sel == 0) begin
                     width_v   = acc;
                     field_sel = 1;
                     st = skip_header_byte(b);
                  end else if (field_sel == 1) begin
                     height_v  = acc;
                     field_sel = 2;
                     st = skip_header_byte(b);
                  end else begin
                     st = close_header();
                  end
               end
            end
            PIXEL_DATA: begin
               if (w.is_end) begin
                  st = fail_with(ppmp6_pkg::ST_TRUNC);
               end else begin
                  st                = ppmp6_pkg::ST_PIXEL;
                  r.pixel_value     = b;
                  r.channel_index   = chan;
                  r.column          = col_n[15:0];
                  r.row             = row_n[15:0];
                  r.last_pixel_byte = chan == ppmp6_pkg::CH_BLUE && col_n == width_v - 1 &&
                                      row_n == height_v - 1;
                  // advance channel, then column, then row
                  if (r.last_pixel_byte) begin
                     phase = PIXELS_DONE;
                  end else if (chan < ppmp6_pkg::CH_BLUE) begin
                     chan++;
                  end else begin
                     chan = 0;
                     col_n++;
                     if (col_n >= width_v) begin
                        col_n = 0;
                        row_n++;
                     end
                  end
               end
            end
            PIXELS_DONE: st = w.is_end ? ppmp6_pkg::ST_DONE : ppmp6_pkg::ST_EXTRA;
            default: st = ppmp6_pkg::ST_AFTER;
         endcase
         r.status       = st;
         r.image_width  = width_v[15:0];
         r.image_height = height_v[15:0];
         awaited_results.push_back(r);
      endfunction

      task report(string what);
         if (mismatches < MAX_PRINTED) $display("MISMATCH: %s", what);
         mismatches++;
      endtask

      task compare_field(string name, int unsigned got, int unsigned want);
         if (got != want)
            report($sformatf("result %0d %s: got %0d, want %0d",
                             results_seen, name, got, want));
      endtask

      task match_result(ppmp6_pkg::rsp_type got);
         ppmp6_pkg::rsp_type want;
         status_tally[got.status]++;
         if (awaited_results.size() == 0) begin
            report($sformatf("result %0d arrived with none outstanding", results_seen));
         end else begin
            want = awaited_results.pop_front();
            compare_field("status", got.status, want.status);
            compare_field("image_width", got.image_width, want.image_width);
            compare_field("image_height", got.image_height, want.image_height);
            compare_field("pixel_value", got.pixel_value, want.pixel_value);
            compare_field("channel_index", got.channel_index, want.channel_index);
            compare_field("column", got.column, want.column);
            compare_field("row", got.row, want.row);
            compare_field("last_pixel_byte", got.last_pixel_byte, want.last_pixel_byte);
         end
         results_seen++;
      endtask
   endclass

   logic               clock;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   ppmp6_pkg::req_type req_data  = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   ppmp6_pkg::rsp_type rsp_data;

   p6_parse_tracker    tracker;
   ppmp6_pkg::req_type stream_q[$];
   int                 header_len;
   bit                 steady;
   int                 stall_left;
   int                 quiet_cycles;

   ppm_p6_stream_parser dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // note accepted byte words and check accepted result words
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.match_result(rsp_data);
      if (!reset && req_valid && !req_stall) tracker.take_byte_word(req_data);
   end

   // stall the result side in bursts, never while running steady
   always @(posedge clock) begin
      if (reset || steady) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if (rsp_stall) begin
         rsp_stall  <= 1'b0;
         stall_left <= $urandom_range(0, 20);
      end else begin
         rsp_stall  <= 1'b1;
         stall_left <= pick_gap();
      end
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Timeout: no word moved for %0d cycles", QUIET_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic put_byte(input logic [7:0] b);
      ppmp6_pkg::req_type w;
      w.data_byte = b;
      w.is_end    = 1'b0;
      stream_q.push_back(w);
   endtask

   task automatic put_end();
      ppmp6_pkg::req_type w;
      w.data_byte = 8'($urandom_range(0, 255));
      w.is_end    = 1'b1;
      stream_q.push_back(w);
   endtask

   // decimal digits, sometimes behind a run of leading zeros
   task automatic put_number(input int unsigned v);
      string s;
      s = $sformatf("%0d", v);
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 8)) put_byte(ppmp6_pkg::CHAR_ZERO);
      foreach (s[i]) put_byte(s[i]);
   endtask

   // whitespace and comments running up to a line feed
   task automatic put_blanks(input int min_n);
      logic [7:0] b;
      repeat ($urandom_range(min_n, 4)) begin
         if ($urandom_range(0, 9) < 7) begin
            case ($urandom_range(0, 3))
               0: put_byte(CHAR_SPACE);
               1: put_byte(CHAR_TAB);
               2: put_byte(CHAR_CR);
               default: put_byte(ppmp6_pkg::CHAR_LF);
            endcase
         end else begin
            put_byte(ppmp6_pkg::CHAR_HASH);
            repeat ($urandom_range(0, 6)) begin
               do b = 8'($urandom_range(0, 255)); while (b == ppmp6_pkg::CHAR_LF);
               put_byte(b);
            end
            put_byte(ppmp6_pkg::CHAR_LF);
         end
      end
   endtask

   task automatic put_header(input int unsigned wv, hv, mv);
      logic [7:0] b;
      put_byte(ppmp6_pkg::CHAR_P);
      put_byte(ppmp6_pkg::CHAR_SIX);
      put_blanks(0);
      put_number(wv);
      put_blanks(1);
      put_number(hv);
      put_blanks(1);
      put_number(mv);
      // any non-digit closes maxval
      do b = 8'($urandom_range(0, 255)); while (is_digit(b));
      put_byte(b);
      header_len = stream_q.size();
   endtask

   // hold a word on the request side until the block takes it
   task automatic send_word(input ppmp6_pkg::req_type w);
      int gap;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   initial begin : stimulus
      int                 r;
      int                 k;
      int unsigned        wv;
      int unsigned        hv;
      int unsigned        mv;
      logic [7:0]         b;
      ppmp6_pkg::req_type w;
      stream_kind_type    kind;

      tracker = new();
      steady  = 1'b0;

      r = $urandom_range(0, 9);
      if (r < 5) kind = CLEAN_FILE;
      else if (r == 5) kind = CUT_SHORT;
      else if (r == 6) kind = BAD_MAGIC;
      else if (r == 7) kind = STRAY_CHAR;
      else if (r == 8) kind = OVERSIZE;
      else kind = BAD_VALUES;

      wv = $urandom_range(4, 16);
      hv = $urandom_range(2, 10);
      mv = ppmp6_pkg::MAXVAL_OK;
      if ($urandom_range(0, 7) == 0) begin
         wv = 1;
         hv = 1;
      end
      if (kind == OVERSIZE) begin
         // an oversize width, height or maxval; the height case puts the largest legal width first
         case ($urandom_range(0, 2))
            0: wv = $urandom_range(65536, 999999);
            1: begin
               wv = 32'(NUM_LIMIT);
               hv = $urandom_range(65536, 9999999);
            end
            default: mv = $urandom_range(65536, 999999);
         endcase
      end else if (kind == BAD_VALUES) begin
         case ($urandom_range(0, 2))
            0: wv = 0;
            1: hv = 0;
            default: begin
               mv = $urandom_range(0, 32'(NUM_LIMIT));
               if (mv == ppmp6_pkg::MAXVAL_OK) mv = ppmp6_pkg::MAXVAL_OK + 1;
            end
         endcase
      end

      put_header(wv, hv, mv);
      if (kind != OVERSIZE && kind != BAD_VALUES)
         repeat (wv * hv * 3) put_byte(8'($urandom_range(0, 255)));

      // break the well-formed stream where the kind calls for it
      w.data_byte = 8'($urandom_range(0, 255));
      w.is_end    = 1'b1;
      case (kind)
         CUT_SHORT: begin
            k = ($urandom_range(0, 3) == 0) ? header_len - 1
                                            : $urandom_range(0, stream_q.size() - 1);
            stream_q.insert(k, w);
         end
         BAD_MAGIC: begin
            k = $urandom_range(0, 1);
            do b = 8'($urandom_range(0, 255)); while (b == stream_q[k].data_byte);
            stream_q[k].data_byte = b;
         end
         STRAY_CHAR: begin
            do b = 8'($urandom_range(0, 255));
            while (is_digit(b) || is_blank(b) || b == ppmp6_pkg::CHAR_HASH);
            w.data_byte = b;
            w.is_end    = 1'b0;
            stream_q.insert($urandom_range(2, header_len - 1), w);
         end
         BAD_VALUES: begin
            if ($urandom_range(0, 1) == 0) stream_q[header_len - 1] = w;
         end
         default: ;
      endcase

      // trailing bytes and end markers after the file, or noise after an error
      if (kind == CLEAN_FILE) begin
         k = WORDS_WANTED - stream_q.size();
         if (k < 24) k = 24;
         repeat (k) begin
            if ($urandom_range(0, 9) < 3) put_end();
            else put_byte(8'($urandom_range(0, 255)));
         end
      end else begin
         k = WORDS_WANTED - stream_q.size();
         if (k < 40) k = 40;
         repeat (k) begin
            if ($urandom_range(0, 3) == 0) put_end();
            else put_byte(8'($urandom_range(0, 255)));
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (stream_q[i]) begin
         if (i % 64 == 0) steady = ($urandom_range(0, 3) == 0);
         send_word(stream_q[i]);
      end
      req_valid <= 1'b0;
      steady = 1'b0;

      // drain the outstanding results, then watch for strays
      do @(posedge clock); while (tracker.awaited_results.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran a %s stream of %0d words, image %0dx%0d, maxval %0d.",
               kind.name(), stream_q.size(), wv, hv, mv);
      $display("Results: %0d header, %0d pixel, %0d extra, %0d end, %0d error, %0d after error.",
               tracker.status_tally[ppmp6_pkg::ST_HEADER] +
               tracker.status_tally[ppmp6_pkg::ST_HDR_OK],
               tracker.status_tally[ppmp6_pkg::ST_PIXEL],
               tracker.status_tally[ppmp6_pkg::ST_EXTRA],
               tracker.status_tally[ppmp6_pkg::ST_DONE],
               tracker.status_tally[ppmp6_pkg::ST_MAGIC] +
               tracker.status_tally[ppmp6_pkg::ST_SYNTAX] +
               tracker.status_tally[ppmp6_pkg::ST_LARGE] +
               tracker.status_tally[ppmp6_pkg::ST_VALUES] +
               tracker.status_tally[ppmp6_pkg::ST_TRUNC],
               tracker.status_tally[ppmp6_pkg::ST_AFTER]);
      if (tracker.mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
